// File: rtl/lkv_pkg.sv
// Package for the LRU key-value cache: field widths, request codes and the
// entry type that moves along the row of cells. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lkv_pkg;

    // Field widths fixed by the request and result formats.
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 31;
    localparam int CAP_W       = 5;
    localparam int RD_W        = 32;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 72;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request kinds carried on s_tuser.
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // Read value returned by a get that misses.
    localparam logic [RD_W-1:0] RD_MISS = {RD_W{1'b1}};

    // One stored entry as handed from cell to cell.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage
`default_nettype wire

// File: rtl/lkv_cell.sv
// One cell of the recency-ordered row: holds one entry and compares its key
// with the request. Depends on lkv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lkv_cell
    import lkv_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load_en,    // take the entry offered by the neighbour
    input  wire entry_t           entry_in,   // neighbour towards the most recent end
    input  wire logic [KEY_W-1:0] req_key,
    output entry_t                entry_out,
    output logic                  match
);

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    // Valid mark is control state and is cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_en) begin
            valid_reg <= entry_in.valid;
        end
    end

    // Key and value follow the valid mark without a reset.
    always_ff @(posedge aclk) begin
        if (load_en) begin
            key_reg   <= entry_in.key;
            value_reg <= entry_in.value;
        end
    end

    // Associative compare against the request key.
    assign match = valid_reg && (key_reg == req_key);

    assign entry_out.valid = valid_reg;
    assign entry_out.key   = key_reg;
    assign entry_out.value = value_reg;

endmodule
`default_nettype wire

// File: rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache: a row of cells
// ordered by recency, the occupancy count and the result register.
// Depends on lkv_pkg and lkv_cell.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid / s_tready  s_tuser: req_type; s_tdata: key, value
//  m_        out        m_tvalid / m_tready  m_tdata: found, read_value, evicted,
//                                            evicted_key
//  cfg_      in         cfg_wr_en            cfg_wr_data: capacity
//
// All cells compare in parallel and the row shifts by one place towards the least
// recent end in the same edge, so a request can be taken every cycle while the
// result register is free or being emptied.
// The result appears on m_ in the cycle after the request is accepted.
// Reset clears all valid marks and the occupancy at once; no clearing pass.
// A stalled result holds s_tready low until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 s_tuser,     // [0] req_type
    input  wire logic [S_TDATA_W-1:0] s_tdata,     // [30:0] key, [61:31] value
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,     // [0] found, [32:1] read_value,
                                                   // [33] evicted, [64:34] evicted_key
    input  wire logic                 cfg_wr_en,
    input  wire logic     [CAP_W-1:0] cfg_wr_data  // capacity
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > CAP_W) ? OW : CAP_W;

    logic [CAP_W-1:0]     capacity_reg;
    logic [OW-1:0]        occupancy_reg, occupancy_next;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic             accept;
    logic             is_put;
    logic [KEY_W-1:0] req_key;
    logic [VAL_W-1:0] req_value;

    entry_t             cell_q   [ENTRIES];
    entry_t             cell_in  [ENTRIES];
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] load_vec;

    logic             hit;
    logic [IW-1:0]    hit_idx;
    logic [VAL_W-1:0] hit_value;
    logic [KEY_W-1:0] last_key;
    logic [IW-1:0]    last_idx;
    logic [OW-1:0]    occ_less;
    logic [CW-1:0]    eff_cap;
    logic [CW-1:0]    cap_ext;
    logic             full;
    logic             shift;
    logic [IW-1:0]    limit;
    entry_t           head;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign is_put    = (s_tuser == REQ_PUT);
    assign req_key   = s_tdata[KEY_W-1:0];
    assign req_value = s_tdata[KEY_W+VAL_W-1:KEY_W];

    // Capacity register; user writes it only while the cache is idle, not enforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Effective capacity: zero counts as one, large values saturate.
    always_comb begin
        cap_ext = CW'(capacity_reg);
        if (capacity_reg == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > CW'(ENTRIES)) begin
            eff_cap = CW'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign full     = CW'(occupancy_reg) >= eff_cap;
    assign occ_less = occupancy_reg - OW'(1);
    assign last_idx = occ_less[IW-1:0];

    // Gather hit position, hit value and the least recent key from the row.
    always_comb begin
        hit_idx   = '0;
        hit_value = '0;
        last_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_vec[i]) begin
                hit_idx   = hit_idx | IW'(i);
                hit_value = hit_value | cell_q[i].value;
            end
            if (last_idx == IW'(i)) begin
                last_key = last_key | cell_q[i].key;
            end
        end
    end

    assign hit = |match_vec;

    // A hit moves its entry to the front; an insert pushes the row back by one,
    // dropping the least recent entry when the cache is full.
    always_comb begin
        shift = accept && (hit || is_put);
        if (hit) begin
            limit = hit_idx;
        end else if (full) begin
            limit = last_idx;
        end else begin
            limit = occupancy_reg[IW-1:0];
        end
        head.valid = 1'b1;
        head.key   = req_key;
        head.value = is_put ? req_value : hit_value;
    end

    // Row of cells, each fed by its more recent neighbour.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_in[g] = head;
        end else begin : g_body
            assign cell_in[g] = cell_q[g-1];
        end
        assign load_vec[g]  = shift && (IW'(g) <= limit);
        assign valid_vec[g] = cell_q[g].valid;

        lkv_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load_en   (load_vec[g]),
            .entry_in  (cell_in[g]),
            .req_key   (req_key),
            .entry_out (cell_q[g]),
            .match     (match_vec[g])
        );
    end

    // Occupancy grows only on an insert into a cache that is not full.
    always_comb begin
        occupancy_next = occupancy_reg;
        if (accept && is_put && !hit && !full) begin
            occupancy_next = occupancy_reg + OW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupancy_reg <= '0;
        end else begin
            occupancy_reg <= occupancy_next;
        end
    end

    // Result word for the accepted request.
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[0] = hit;
        if (!is_put) begin
            m_tdata_next[RD_W:1] = hit ? RD_W'(hit_value) : RD_MISS;
        end
        if (is_put && !hit && full) begin
            m_tdata_next[RD_W+1]                  = 1'b1;
            m_tdata_next[RD_W+KEY_W+1:RD_W+2]     = last_key;
        end
    end

    // Output register decouples the result from the next request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Keys in the row are unique, so at most one cell matches.
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("more than one cell matched the request key");

    // Valid entries are exactly as many as the occupancy count.
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(occupancy_reg))
        else $error("occupancy disagrees with the valid marks");

    // Valid entries sit packed at the most recent end of the row.
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec & (valid_vec + ENTRIES'(1))) == '0))
        else $error("a gap was found among the valid cells");

    // Every accepted request leaves a result waiting in the next cycle.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid_reg)
        else $error("accepted request produced no result");

endmodule
`default_nettype wire

// File: tb/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key-value cache: a directed table followed by
// random get/put traffic over several capacity settings, checked by a shadow cache.
// Depends on lkv_pkg and lru_key_value_cache.
`timescale 1ns / 1ps
module tb_lru_key_value_cache
    import lkv_pkg::*;
();

    localparam int ENTRIES        = 16;
    localparam int PHASE_COUNT    = 9;
    localparam int PHASE_REQUESTS = 56;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    // Capacity per random phase, phase 0 in the lowest bits.
    localparam logic [PHASE_COUNT*CAP_W-1:0] CAP_PLAN =
        {5'd16, 5'd8, 5'd17, 5'd2, 5'd31, 5'd0, 5'd5, 5'd1, 5'd16};

    typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_kind_t;

    typedef struct packed {
        logic             found;
        logic [RD_W-1:0]  read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } lookup_result_t;

    typedef struct {
        bit             typed;
        lookup_result_t want;
    } typed_check_t;

    typedef struct {
        row_kind_t        kind;
        logic             op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [CAP_W-1:0] cap;
        bit               typed;
        lookup_result_t   want;
    } stim_row_t;

    // Block ports.
    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic                 s_tuser     = REQ_GET;  // [0] req_type
    logic [S_TDATA_W-1:0] s_tdata     = '0;       // [30:0] key, [61:31] value
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;                // [0] found, [32:1] read_value,
                                                  // [33] evicted, [64:34] evicted_key
    logic                 cfg_wr_en   = 1'b0;
    logic     [CAP_W-1:0] cfg_wr_data = '0;       // capacity

    // Shadow copy of the cache contents and its capacity register.
    bit               shadow_valid [ENTRIES];
    logic [KEY_W-1:0] shadow_key   [ENTRIES];
    logic [VAL_W-1:0] shadow_value [ENTRIES];
    logic [3:0]       shadow_rank  [ENTRIES];
    logic [CAP_W-1:0] shadow_fill = '0;
    logic [CAP_W-1:0] shadow_cap  = CAP_RESET;

    lookup_result_t   awaited_results [$];
    typed_check_t     typed_checks [$];
    stim_row_t        stim_plan [$];

    // Handshake state sampled mid-cycle, consumed at the following rising edge.
    bit                   s_take;
    bit                   m_take;
    logic                 s_kind_seen;
    logic [S_TDATA_W-1:0] s_data_seen;
    logic [M_TDATA_W-1:0] m_data_seen;

    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;

    lru_key_value_cache #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The entry in the given slot becomes most recent; younger entries age by one.
    function automatic void make_recent(input int slot);
        logic [3:0] was;
        was = shadow_rank[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && shadow_rank[i] < was)
                shadow_rank[i] = shadow_rank[i] + 1'b1;
        shadow_rank[slot] = '0;
    endfunction

    // Applies one request to the shadow cache and returns the result it must give.
    function automatic lookup_result_t predict_lookup(input logic op,
            input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val);
        lookup_result_t res;
        int hit;
        int victim;
        int slot;
        logic [CAP_W-1:0] limit;
        res    = '0;
        hit    = -1;
        victim = -1;
        slot   = -1;
        // A capacity of zero behaves as one; anything above the array size saturates.
        if (shadow_cap == '0)
            limit = CAP_W'(1);
        else if (shadow_cap > ENTRIES)
            limit = CAP_W'(ENTRIES);
        else
            limit = shadow_cap;
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == key)
                hit = i;
        if (op == REQ_GET) begin
            if (hit >= 0) begin
                res.found      = 1'b1;
                res.read_value = {1'b0, shadow_value[hit]};
                make_recent(hit);
            end else begin
                res.read_value = RD_MISS;
            end
        end else if (hit >= 0) begin
            res.found         = 1'b1;
            shadow_value[hit] = val;
            make_recent(hit);
        end else if (shadow_fill >= limit) begin
            // Full: the least recent entry gives up its slot and occupancy is unchanged.
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                    victim = i;
            if (victim >= 0) begin
                res.evicted          = 1'b1;
                res.evicted_key      = shadow_key[victim];
                shadow_key[victim]   = key;
                shadow_value[victim] = val;
                make_recent(victim);
            end
        end else begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !shadow_valid[i])
                    slot = i;
            if (slot >= 0) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (shadow_valid[i])
                        shadow_rank[i] = shadow_rank[i] + 1'b1;
                shadow_valid[slot] = 1'b1;
                shadow_key[slot]   = key;
                shadow_value[slot] = val;
                shadow_rank[slot]  = '0;
                shadow_fill        = shadow_fill + 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] rand31();
        logic [31:0] rnd;
        rnd = $urandom;
        return rnd[KEY_W-1:0];
    endfunction

    // Rows of the directed table.
    function automatic void plan_request(input logic op, input logic [KEY_W-1:0] key,
            input logic [VAL_W-1:0] val);
        stim_row_t row;
        row       = '{kind: ROW_REQUEST, default: '0};
        row.kind  = ROW_REQUEST;
        row.op    = op;
        row.key   = key;
        row.val   = val;
        stim_plan.push_back(row);
    endfunction

    function automatic void plan_checked(input logic op, input logic [KEY_W-1:0] key,
            input logic [VAL_W-1:0] val, input logic found, input logic [RD_W-1:0] rd,
            input logic evicted, input logic [KEY_W-1:0] evicted_key);
        stim_row_t row;
        row       = '{kind: ROW_REQUEST, default: '0};
        row.kind  = ROW_REQUEST;
        row.op    = op;
        row.key   = key;
        row.val   = val;
        row.typed = 1'b1;
        row.want  = '{found, rd, evicted, evicted_key};
        stim_plan.push_back(row);
    endfunction

    function automatic void plan_capacity(input logic [CAP_W-1:0] cap);
        stim_row_t row;
        row      = '{kind: ROW_CAPACITY, default: '0};
        row.kind = ROW_CAPACITY;
        row.cap  = cap;
        stim_plan.push_back(row);
    endfunction

    // Presents one request and waits until it is taken; an optional gap comes first.
    task automatic issue_request(input logic op, input logic [KEY_W-1:0] key,
            input logic [VAL_W-1:0] val, input bit typed, input lookup_result_t want);
        typed_check_t chk;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        chk.typed = typed;
        chk.want  = want;
        typed_checks.push_back(chk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, val, key};
        do @(posedge aclk); while (!s_take);
    endtask

    // Stops sending and waits until every outstanding result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (awaited_results.size() != 0);
        @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_cap   = cap;
    endtask

    // Sample both handshakes halfway through the cycle, when everything has settled.
    always @(negedge aclk) begin
        s_take      = (aresetn === 1'b1) && (s_tvalid === 1'b1) && (s_tready === 1'b1);
        m_take      = (aresetn === 1'b1) && (m_tvalid === 1'b1) && (m_tready === 1'b1);
        s_kind_seen = s_tuser;
        s_data_seen = s_tdata;
        m_data_seen = m_tdata;
    end

    function automatic void check_field(input string name, input logic [RD_W-1:0] want,
            input logic [RD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Predict on each accepted request, compare each accepted result in order.
    always @(posedge aclk) begin
        lookup_result_t want;
        lookup_result_t got;
        typed_check_t   chk;
        if (s_take) begin
            want = predict_lookup(s_kind_seen, s_data_seen[KEY_W-1:0],
                                  s_data_seen[KEY_W+VAL_W-1:KEY_W]);
            chk  = typed_checks.pop_front();
            awaited_results.push_back(chk.typed ? chk.want : want);
        end
        if (m_take) begin
            got.found       = m_data_seen[0];
            got.read_value  = m_data_seen[32:1];
            got.evicted     = m_data_seen[33];
            got.evicted_key = m_data_seen[64:34];
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("found", RD_W'(want.found), RD_W'(got.found));
                check_field("read_value", want.read_value, got.read_value);
                check_field("evicted", RD_W'(want.evicted), RD_W'(got.evicted));
                check_field("evicted_key", RD_W'(want.evicted_key), RD_W'(got.evicted_key));
            end
        end
    end

    // Give up when neither channel has moved for too long.
    always @(posedge aclk) begin
        if (s_take || m_take) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: ready by default, with occasional short back-pressure bursts.
    initial begin : result_sink
        int unsigned hold;
        @(posedge aclk);
        forever begin
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                hold = $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        stim_row_t        row;
        lookup_result_t   none;
        logic [KEY_W-1:0] key_pool [24];
        logic [KEY_W-1:0] pick;
        int unsigned      pool_n;
        none = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: empty cache, key and value extremes, update, eviction,
        // capacity zero, capacity lowered below occupancy and capacity above the array.
        plan_checked(REQ_GET, 31'h0000_0000, 31'h0000_0000, 1'b0, RD_MISS, 1'b0, '0);
        plan_checked(REQ_GET, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, RD_MISS, 1'b0, '0);
        plan_checked(REQ_PUT, 31'h0000_0000, 31'h7FFF_FFFF, 1'b0, '0, 1'b0, '0);
        plan_checked(REQ_PUT, 31'h7FFF_FFFF, 31'h0000_0000, 1'b0, '0, 1'b0, '0);
        plan_checked(REQ_GET, 31'h0000_0000, 31'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0, '0);
        plan_checked(REQ_GET, 31'h7FFF_FFFF, 31'h1234_5678, 1'b1, '0, 1'b0, '0);
        plan_checked(REQ_PUT, 31'h0000_0000, 31'h0000_0005, 1'b1, '0, 1'b0, '0);
        plan_capacity(5'd2);
        plan_checked(REQ_PUT, 31'h0000_0003, 31'h0000_0009, 1'b0, '0, 1'b1, 31'h7FFF_FFFF);
        plan_checked(REQ_GET, 31'h7FFF_FFFF, 31'h0000_0000, 1'b0, RD_MISS, 1'b0, '0);
        plan_capacity(5'd0);
        plan_request(REQ_PUT, 31'd100, 31'd1);
        plan_request(REQ_PUT, 31'd200, 31'd2);
        plan_request(REQ_GET, 31'd100, 31'd0);
        plan_capacity(5'd31);
        plan_request(REQ_PUT, 31'd50, 31'd55);
        plan_request(REQ_PUT, 31'd51, 31'h2AAA_AAAA);
        plan_request(REQ_GET, 31'd50, 31'd0);
        plan_request(REQ_PUT, 31'h5555_5555, 31'h5555_5555);
        plan_request(REQ_GET, 31'd51, 31'd0);
        plan_request(REQ_GET, 31'd12345, 31'd0);
        plan_request(REQ_PUT, 31'd100, 31'h7FFF_FFFF);
        plan_capacity(5'd16);

        gap_pct   = 20;
        stall_pct = 20;
        foreach (stim_plan[r]) begin
            row = stim_plan[r];
            if (row.kind == ROW_CAPACITY)
                write_capacity(row.cap);
            else
                issue_request(row.op, row.key, row.val, row.typed, row.want);
        end

        // Random phases: each draws keys mostly from a small pool so that hits,
        // updates and evictions all occur; the last phase runs without idling.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_capacity(CAP_PLAN[ph*CAP_W +: CAP_W]);
            if (ph == PHASE_COUNT - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = 20 * $urandom_range(0, 2);
                stall_pct = 20 * $urandom_range(0, 2);
            end
            pool_n = $urandom_range(2, 24);
            for (int i = 0; i < 24; i++)
                key_pool[i] = rand31();
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if ($urandom_range(0, 9) == 0)
                    pick = rand31();
                else
                    pick = key_pool[$urandom_range(0, pool_n - 1)];
                issue_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, pick, rand31(),
                              1'b0, none);
            end
        end

        // Let the last results drain, then watch for any stray output.
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
